@@ sv/aff_pkg.sv @@
// ----------------------------------------------------------------------------
// aff_pkg
// Shared constants and types of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package aff_pkg;

   localparam int ARENA_BYTES     = 65536;
   localparam int HEADER_BYTES    = 8;
   localparam int MIN_SPLIT_BYTES = 4;
   localparam int STORE_DEPTH     = ARENA_BYTES / 4;
   localparam int ADDR_W          = $clog2(STORE_DEPTH);
   localparam int POS_W           = 18;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_COLLECT = 2'd2,
      ACT_SIZE    = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUMP,
      ST_FIT_RD,
      ST_FIT_EV,
      ST_SPLIT,
      ST_COL_RD,
      ST_COL_EV,
      ST_COL_END,
      ST_OFF_RD,
      ST_OFF_EV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [16:0]       wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctrl_type;

endpackage

@@ sv/aff_header_ram.sv @@
// ----------------------------------------------------------------------------
// aff_header_ram
// Block header store: one 17-bit entry per arena word, registered read.
// ----------------------------------------------------------------------------
module aff_header_ram (
   input  logic                 clock,
   input  aff_pkg::mem_ctrl_type ctrl,
   output logic [16:0]          rd_data
);

   logic [16:0] mem [aff_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data <= mem[ctrl.rd_addr];
      end
   end

endmodule

@@ sv/arena_first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// arena_first_fit_allocator
// First-fit heap allocator with coalescing over a header memory.
// ----------------------------------------------------------------------------
// channel  ports                                   transfer
// request  req_start/req_busy + action,len,offset  start && !busy
// result   rsp_strobe + ok,offset,length           strobe, one cycle
// config   csr_wr_en + csr_wr_data (arena_len)     wr_en
//
// Bump alloc answers through BUMP then DONE, free and size through OFF_RD,
// OFF_EV and DONE (OFF_RD straight to DONE for a bad offset), an oversized
// alloc straight from IDLE to DONE; IDLE follows every result. Search and
// collect walk the block list one header at a time (memory read then
// evaluate), and an alloc makes up to three walks. Reset clears top and sets
// arena_len to 65536; the header memory needs no clear. The receiver cannot
// stall; busy stays high up to and including the result strobe cycle.
module arena_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        req_busy,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_req_length,
   input  logic [15:0] req_data_offset,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   output logic        rsp_strobe,
   output logic        rsp_ok,
   output logic [15:0] rsp_result_offset,
   output logic [15:0] rsp_block_length
);

   localparam int AW = aff_pkg::ADDR_W;
   localparam int PW = aff_pkg::POS_W;

   aff_pkg::state_type    state_ff, state_in;
   aff_pkg::mem_ctrl_type ctrl;
   logic [16:0]           rd_data;

   logic [16:0] arena_len_ff;
   logic [16:0] top_ff, top_in;
   logic [1:0]  act_ff;
   logic [16:0] need_ff;
   logic [15:0] doff_ff;
   logic [PW-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        retry_ff, retry_in;
   logic        ok_ff, ok_in;
   logic [15:0] roff_ff, roff_in, blen_ff, blen_in;
   logic [15:0] split_len_ff, split_len_in;

   logic [16:0] need_c;
   logic [17:0] limit_c;
   logic [15:0] hlen;
   logic        hused;
   logic [PW-1:0] next_pos;
   logic [16:0] doff_pos;

   aff_header_ram u_ram (.clock(clock), .ctrl(ctrl), .rd_data(rd_data));

   assign need_c   = ({1'b0, req_req_length} + 17'd3) & ~17'd3;
   assign limit_c  = (arena_len_ff < 17'(aff_pkg::ARENA_BYTES)) ?
                     {1'b0, arena_len_ff} : 18'(aff_pkg::ARENA_BYTES);
   assign hlen     = rd_data[15:0];
   assign hused    = rd_data[16];
   assign next_pos = pos_ff + PW'(aff_pkg::HEADER_BYTES) + PW'(hlen);
   assign doff_pos = {1'b0, doff_ff} - 17'(aff_pkg::HEADER_BYTES);
   assign req_busy = (state_ff != aff_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aff_pkg::ST_IDLE;
         top_ff       <= '0;
         arena_len_ff <= 17'd65536;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         if (csr_wr_en) begin
            arena_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_start && !req_busy) begin
         act_ff  <= req_action;
         need_ff <= need_c;
         doff_ff <= req_data_offset;
      end
      pos_ff       <= pos_in;
      start_ff     <= start_in;
      cnt_ff       <= cnt_in;
      retry_ff     <= retry_in;
      ok_ff        <= ok_in;
      roff_ff      <= roff_in;
      blen_ff      <= blen_in;
      split_len_ff <= split_len_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aff_pkg::ST_IDLE: begin
            if (req_start) begin
               case (aff_pkg::action_type'(req_action))
                  aff_pkg::ACT_ALLOC: begin
                     if (need_c[16]) state_in = aff_pkg::ST_DONE;
                     else if (18'(top_ff) + 18'(need_c) + 18'(aff_pkg::HEADER_BYTES)
                              <= limit_c) state_in = aff_pkg::ST_BUMP;
                     else state_in = aff_pkg::ST_FIT_RD;
                  end
                  aff_pkg::ACT_COLLECT: state_in = aff_pkg::ST_COL_RD;
                  default: state_in = aff_pkg::ST_OFF_RD;
               endcase
            end
         end
         aff_pkg::ST_BUMP: state_in = aff_pkg::ST_DONE;
         aff_pkg::ST_FIT_RD: begin
            if (pos_ff < PW'(top_ff)) state_in = aff_pkg::ST_FIT_EV;
            else if (!retry_ff) state_in = aff_pkg::ST_COL_RD;
            else state_in = aff_pkg::ST_DONE;
         end
         aff_pkg::ST_FIT_EV: begin
            if (!hused && {1'b0, hlen} >= need_ff) begin
               if (({1'b0, hlen} - need_ff) >= 17'(aff_pkg::HEADER_BYTES
                                                + aff_pkg::MIN_SPLIT_BYTES))
                  state_in = aff_pkg::ST_SPLIT;
               else state_in = aff_pkg::ST_DONE;
            end else state_in = aff_pkg::ST_FIT_RD;
         end
         aff_pkg::ST_SPLIT: state_in = aff_pkg::ST_DONE;
         aff_pkg::ST_COL_RD:
            state_in = (pos_ff < PW'(top_ff)) ? aff_pkg::ST_COL_EV : aff_pkg::ST_COL_END;
         aff_pkg::ST_COL_EV: state_in = aff_pkg::ST_COL_RD;
         aff_pkg::ST_COL_END:
            state_in = (act_ff == aff_pkg::ACT_ALLOC) ? aff_pkg::ST_FIT_RD : aff_pkg::ST_DONE;
         aff_pkg::ST_OFF_RD: begin
            if (doff_ff < 16'(aff_pkg::HEADER_BYTES) ||
                (doff_pos >> 2) >= 17'(aff_pkg::STORE_DEPTH))
               state_in = aff_pkg::ST_DONE;
            else state_in = aff_pkg::ST_OFF_EV;
         end
         aff_pkg::ST_OFF_EV: state_in = aff_pkg::ST_DONE;
         aff_pkg::ST_DONE: state_in = aff_pkg::ST_IDLE;
         default: state_in = aff_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      ctrl         = '0;
      top_in       = top_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      retry_in     = retry_ff;
      ok_in        = ok_ff;
      roff_in      = roff_ff;
      blen_in      = blen_ff;
      split_len_in = split_len_ff;
      case (state_ff)
         aff_pkg::ST_IDLE: begin
            pos_in   = '0;
            start_in = '0;
            cnt_in   = '0;
            retry_in = 1'b0;
            ok_in    = (req_action != aff_pkg::ACT_ALLOC);
            roff_in  = '0;
            blen_in  = '0;
         end
         aff_pkg::ST_BUMP: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = top_ff[AW+1:2];
            ctrl.wr_data = {1'b1, need_ff[15:0]};
            roff_in      = 16'(top_ff + 17'(aff_pkg::HEADER_BYTES));
            blen_in      = need_ff[15:0];
            ok_in        = 1'b1;
            top_in       = top_ff + need_ff + 17'(aff_pkg::HEADER_BYTES);
         end
         aff_pkg::ST_FIT_RD, aff_pkg::ST_COL_RD: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = pos_ff[AW+1:2];
            if (state_ff == aff_pkg::ST_FIT_RD && pos_ff >= PW'(top_ff)) begin
               pos_in   = '0;
               start_in = '0;
               cnt_in   = '0;
               retry_in = 1'b1;
            end
         end
         aff_pkg::ST_FIT_EV: begin
            pos_in = next_pos;
            if (!hused && {1'b0, hlen} >= need_ff) begin
               ok_in   = 1'b1;
               roff_in = 16'(pos_ff + PW'(aff_pkg::HEADER_BYTES));
               ctrl.wr_en   = 1'b1;
               ctrl.wr_addr = pos_ff[AW+1:2];
               if (({1'b0, hlen} - need_ff) >= 17'(aff_pkg::HEADER_BYTES
                                                + aff_pkg::MIN_SPLIT_BYTES)) begin
                  ctrl.wr_data = {1'b1, need_ff[15:0]};
                  blen_in      = need_ff[15:0];
                  split_len_in = hlen - need_ff[15:0] - 16'(aff_pkg::HEADER_BYTES);
               end else begin
                  ctrl.wr_data = {1'b1, hlen};
                  blen_in      = hlen;
               end
            end
         end
         aff_pkg::ST_SPLIT: begin
            // remainder header behind the allocated block
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = AW'((PW'(roff_ff) + PW'(need_ff)) >> 2);
            ctrl.wr_data = {1'b0, split_len_ff};
         end
         aff_pkg::ST_COL_EV: begin
            pos_in = next_pos;
            if (!hused) begin
               if (cnt_ff == '0) start_in = pos_ff;
               cnt_in = cnt_ff + 16'd1;
            end else begin
               if (cnt_ff > 16'd1) begin
                  ctrl.wr_en   = 1'b1;
                  ctrl.wr_addr = start_ff[AW+1:2];
                  ctrl.wr_data = {1'b0, 16'(pos_ff - start_ff
                                            - PW'(aff_pkg::HEADER_BYTES))};
               end
               cnt_in = '0;
            end
         end
         aff_pkg::ST_COL_END: begin
            if (cnt_ff > 16'd1) begin
               ctrl.wr_en   = 1'b1;
               ctrl.wr_addr = start_ff[AW+1:2];
               ctrl.wr_data = {1'b0, 16'(pos_ff - start_ff
                                         - PW'(aff_pkg::HEADER_BYTES))};
            end
            pos_in = '0;
            cnt_in = '0;
         end
         aff_pkg::ST_OFF_RD: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = doff_pos[AW+1:2];
            if (doff_ff < 16'(aff_pkg::HEADER_BYTES) ||
                (doff_pos >> 2) >= 17'(aff_pkg::STORE_DEPTH))
               ok_in = 1'b0;
         end
         aff_pkg::ST_OFF_EV: begin
            if (act_ff == aff_pkg::ACT_FREE) begin
               ctrl.wr_en   = 1'b1;
               ctrl.wr_addr = doff_pos[AW+1:2];
               ctrl.wr_data = {1'b0, hlen};
            end else begin
               blen_in = hlen;
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe        = (state_ff == aff_pkg::ST_DONE);
   assign rsp_ok            = ok_ff;
   assign rsp_result_offset = roff_ff;
   assign rsp_block_length  = blen_ff;

   a_top_align: assert property (@(posedge clock) disable iff (reset)
      top_ff[1:0] == 2'b00) else $error("top not word aligned");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_result_offset == '0 && rsp_block_length == '0))
      else $error("failed result carries data");
   a_top_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aff_pkg::ST_BUMP) |=> (top_ff > $past(top_ff)))
      else $error("bump did not advance top");

endmodule
